/* rtl/core/rth_pkg.sv */
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants for the RGB to hue pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int ChanW         = 8;
  localparam int NumW          = 15;
  localparam int QuoW          = 7;
  localparam int QuoIdxW       = $clog2(QuoW);
  localparam int StepsPerStage = 2;
  localparam int DivStages     = (QuoW + StepsPerStage - 1) / StepsPerStage;
  localparam int PreW          = 10;
  localparam int HueW          = 8;

  localparam logic [NumW-1:0] HueScale  = NumW'(85);
  localparam logic [PreW-1:0] BaseGreen = PreW'(170);
  localparam logic [PreW-1:0] BaseBlue  = PreW'(340);
  localparam logic [QuoW-1:0] QuoMax    = QuoW'(85);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [ChanW-1:0] dvsr;
    logic [QuoW-1:0]  quo;
    logic             neg;
    sector_t          sector;
    logic             zero;
    logic             tile;
  } div_item_t;

endpackage

/* rtl/core/rth_front.sv */
// ----------------------------------------------------------------------------
// rth_front
// Two stages: max, min, sector and channel difference, then scale by 85.
// ----------------------------------------------------------------------------
module rth_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  output logic                      in_rdy,
  input  logic [rth_pkg::ChanW-1:0] red,
  input  logic [rth_pkg::ChanW-1:0] green,
  input  logic [rth_pkg::ChanW-1:0] blue,
  input  logic                      eot,
  output logic                      out_vld,
  input  logic                      out_rdy,
  output rth_pkg::div_item_t        out_dat
);
  import rth_pkg::*;

  logic             s1_vld_r;
  logic [ChanW-1:0] s1_absdiff_r, s1_absdiff_nxt;
  logic [ChanW-1:0] s1_delta_r, s1_delta_nxt;
  logic             s1_neg_r, s1_neg_nxt;
  sector_t          s1_sector_r, s1_sector_nxt;
  logic             s1_tile_r;
  logic             s1_rdy;

  logic             s2_vld_r;
  div_item_t        s2_dat_r, s2_dat_nxt;
  logic             s2_rdy;

  logic [ChanW-1:0] mx, mn;
  logic [ChanW:0]   diff;

  always_comb begin
    if (red >= green && red >= blue) begin
      s1_sector_nxt = SEC_RED;
      mx            = red;
      diff          = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      s1_sector_nxt = SEC_GREEN;
      mx            = green;
      diff          = {1'b0, blue} - {1'b0, red};
    end else begin
      s1_sector_nxt = SEC_BLUE;
      mx            = blue;
      diff          = {1'b0, red} - {1'b0, green};
    end
    if (red <= green && red <= blue) begin
      mn = red;
    end else if (green <= blue) begin
      mn = green;
    end else begin
      mn = blue;
    end
    s1_delta_nxt   = mx - mn;
    s1_neg_nxt     = diff[ChanW];
    s1_absdiff_nxt = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
  end

  assign s2_rdy = !s2_vld_r || out_rdy;
  assign s1_rdy = !s1_vld_r || s2_rdy;
  assign in_rdy = s1_rdy;

  always_comb begin
    s2_dat_nxt        = '0;
    s2_dat_nxt.rem    = NumW'(s1_absdiff_r) * HueScale;
    s2_dat_nxt.dvsr   = s1_delta_r;
    s2_dat_nxt.quo    = '0;
    s2_dat_nxt.neg    = s1_neg_r;
    s2_dat_nxt.sector = s1_sector_r;
    s2_dat_nxt.zero   = (s1_delta_r == '0);
    s2_dat_nxt.tile   = s1_tile_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_vld;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_absdiff_r <= s1_absdiff_nxt;
      s1_delta_r   <= s1_delta_nxt;
      s1_neg_r     <= s1_neg_nxt;
      s1_sector_r  <= s1_sector_nxt;
      s1_tile_r    <= eot;
    end
    if (s2_rdy) begin
      s2_dat_r <= s2_dat_nxt;
    end
  end

  assign out_vld = s2_vld_r;
  assign out_dat = s2_dat_r;

endmodule

/* rtl/core/rth_div_stage.sv */
// ----------------------------------------------------------------------------
// rth_div_stage
// One register stage of the restoring divider, NumBits quotient bits each.
// ----------------------------------------------------------------------------
module rth_div_stage #(
  parameter int FirstBit = rth_pkg::QuoW - 1,
  parameter int NumBits  = rth_pkg::StepsPerStage
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  rth_pkg::div_item_t in_dat,
  output logic               out_vld,
  input  logic               out_rdy,
  output rth_pkg::div_item_t out_dat
);
  import rth_pkg::*;

  logic            vld_r;
  div_item_t       dat_r, dat_nxt;
  logic [NumW-1:0] rem_v, trial;
  logic [QuoW-1:0] quo_v;

  always_comb begin
    rem_v = in_dat.rem;
    quo_v = in_dat.quo;
    trial = '0;
    for (int k = 0; k < NumBits; k++) begin
      trial = NumW'(in_dat.dvsr) << (FirstBit - k);
      if (!in_dat.zero && rem_v >= trial) begin
        rem_v                          = rem_v - trial;
        quo_v[QuoIdxW'(FirstBit - k)] = 1'b1;
      end
    end
    dat_nxt     = in_dat;
    dat_nxt.rem = rem_v;
    dat_nxt.quo = quo_v;
  end

  assign in_rdy = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_dat = dat_r;

endmodule

/* rtl/core/rth_back.sv */
// ----------------------------------------------------------------------------
// rth_back
// Sign the quotient, add the sector base, round and halve into the hue.
// ----------------------------------------------------------------------------
module rth_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  output logic                     in_rdy,
  input  rth_pkg::div_item_t       in_dat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [rth_pkg::HueW-1:0] out_hue,
  output logic                     out_tile_end
);
  import rth_pkg::*;

  logic            vld_r;
  logic [HueW-1:0] hue_r, hue_nxt;
  logic            tile_r;
  logic [PreW-1:0] base, qv, sum;

  always_comb begin
    case (in_dat.sector)
      SEC_RED:   base = '0;
      SEC_GREEN: base = BaseGreen;
      SEC_BLUE:  base = BaseBlue;
      default:   base = '0;
    endcase
    qv  = in_dat.neg ? PreW'(-PreW'(in_dat.quo)) : PreW'(in_dat.quo);
    sum = base + qv + PreW'(1);
    hue_nxt = in_dat.zero ? '0 : sum[HueW:1];
  end

  assign in_rdy = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      hue_r  <= hue_nxt;
      tile_r <= in_dat.tile;
    end
  end

  assign out_valid    = vld_r;
  assign out_hue      = hue_r;
  assign out_tile_end = tile_r;

endmodule

/* rtl/core/rgb_to_hue_8bit.sv */
// ----------------------------------------------------------------------------
// rgb_to_hue_8bit
// Hue of one RGB pixel on a 256-step circle, fully pipelined.
// ----------------------------------------------------------------------------
//   channel  ports                                     direction
//   in       in_valid in_stall in_red in_green         pixel in
//            in_blue in_end_of_tile
//   out      out_valid out_stall out_hue out_tile_end  hue out
//
// Accepts one item per clock while out_stall is low. Two front stages,
// four divider stages (7 quotient bits, 2 per stage, 1 in the last) and one
// output stage. Reset clears the stage valid bits only.
// out_stall holds each full stage with no empty stage after it; empty stages keep filling, so
// in_stall rises only once the whole pipeline is full.
// ----------------------------------------------------------------------------
module rgb_to_hue_8bit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rth_pkg::ChanW-1:0] in_red,
  input  logic [rth_pkg::ChanW-1:0] in_green,
  input  logic [rth_pkg::ChanW-1:0] in_blue,
  input  logic                      in_end_of_tile,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rth_pkg::HueW-1:0]  out_hue,
  output logic                      out_tile_end
);
  import rth_pkg::*;

  logic      div_vld [DivStages+1];
  logic      div_rdy [DivStages+1];
  div_item_t div_dat [DivStages+1];
  logic      in_rdy;

  assign in_stall = !in_rdy;

  rth_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_valid),
    .in_rdy  (in_rdy),
    .red     (in_red),
    .green   (in_green),
    .blue    (in_blue),
    .eot     (in_end_of_tile),
    .out_vld (div_vld[0]),
    .out_rdy (div_rdy[0]),
    .out_dat (div_dat[0])
  );

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    localparam int Fb = QuoW - 1 - s * StepsPerStage;
    localparam int Nb = (Fb + 1 < StepsPerStage) ? Fb + 1 : StepsPerStage;

    rth_div_stage #(
      .FirstBit (Fb),
      .NumBits  (Nb)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (div_vld[s]),
      .in_rdy  (div_rdy[s]),
      .in_dat  (div_dat[s]),
      .out_vld (div_vld[s+1]),
      .out_rdy (div_rdy[s+1]),
      .out_dat (div_dat[s+1])
    );
  end

  rth_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (div_vld[DivStages]),
    .in_rdy       (div_rdy[DivStages]),
    .in_dat       (div_dat[DivStages]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hue      (out_hue),
    .out_tile_end (out_tile_end)
  );

  a_rem_below_dvsr: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld[DivStages] && !div_dat[DivStages].zero
      |-> div_dat[DivStages].rem < NumW'(div_dat[DivStages].dvsr))
    else $error("divider remainder not below divisor");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld[DivStages] |-> div_dat[DivStages].quo <= QuoMax)
    else $error("divider quotient out of range");

  a_zero_quo: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld[DivStages] && div_dat[DivStages].zero |-> div_dat[DivStages].quo == '0)
    else $error("grey pixel produced a nonzero quotient");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage empty");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives RGB pixels into rgb_to_hue_8bit and checks every hue against a
// predictor that runs in step with accepted input items. A directed set
// covers black, grey, pure primaries, ties and negative hue wrap; a random
// set follows. Input gaps and output stalls are random, but for a steady run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HueStep       = 85;
  localparam int GreenBase     = 170;
  localparam int BlueBase      = 340;
  localparam int RandomPixels  = 1800;
  localparam int DrainCycles   = 10;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [rth_pkg::HueW-1:0] hue;
    logic                     tile;
  } hue_result_t;

  class hue_scoreboard;
    hue_result_t expected_hues[$];
    int          errors = 0;

    function logic [rth_pkg::HueW-1:0] hue_of(int r, int g, int b);
      int mx, mn, d, p;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      d  = mx - mn;
      if (mx == 0 || d == 0) return '0;
      if (mx == r) p = (HueStep * (g - b)) / d;
      else if (mx == g) p = GreenBase + (HueStep * (b - r)) / d;
      else p = BlueBase + (HueStep * (r - g)) / d;
      p = (p + 1) >>> 1;
      return p[rth_pkg::HueW-1:0];
    endfunction

    function void note_pixel(logic [rth_pkg::ChanW-1:0] r, logic [rth_pkg::ChanW-1:0] g,
                             logic [rth_pkg::ChanW-1:0] b, logic tile);
      hue_result_t res;
      res.hue  = hue_of(int'(r), int'(g), int'(b));
      res.tile = tile;
      expected_hues.push_back(res);
    endfunction

    function void check_hue(logic [rth_pkg::HueW-1:0] hue, logic tile);
      hue_result_t want;
      if (expected_hues.size() == 0) begin
        $display("%0t: unexpected item hue %0d tile_end %0b", $time, hue, tile);
        errors++;
        return;
      end
      want = expected_hues.pop_front();
      if (hue !== want.hue) begin
        $display("%0t: hue expected %0d actual %0d", $time, want.hue, hue);
        errors++;
      end
      if (tile !== want.tile) begin
        $display("%0t: tile_end expected %0b actual %0b", $time, want.tile, tile);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [rth_pkg::ChanW-1:0] in_red;
  logic [rth_pkg::ChanW-1:0] in_green;
  logic [rth_pkg::ChanW-1:0] in_blue;
  logic                      in_end_of_tile;
  logic                      out_valid;
  logic                      out_stall;
  logic [rth_pkg::HueW-1:0]  out_hue;
  logic                      out_tile_end;

  hue_scoreboard sb = new();
  bit            steady = 1'b0;
  int            quiet_cycles = 0;

  rgb_to_hue_8bit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_end_of_tile (in_end_of_tile),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_tile_end   (out_tile_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n || steady) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_hue(out_hue, out_tile_end);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(logic [rth_pkg::ChanW-1:0] r, logic [rth_pkg::ChanW-1:0] g,
                            logic [rth_pkg::ChanW-1:0] b, logic tile);
    if (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_end_of_tile <= tile;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_pixel(r, g, b, tile);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [rth_pkg::ChanW-1:0] c[3];
    logic [rth_pkg::ChanW-1:0] m;
    int                        k;
    logic                      tile;
    tile = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 9))
      0: begin
        c[0] = rth_pkg::ChanW'($urandom);
        c[1] = c[0];
        c[2] = c[0];
      end
      1: begin
        m = rth_pkg::ChanW'($urandom_range(1, 255));
        k = $urandom_range(0, 2);
        c[0] = m;
        c[1] = m;
        c[2] = rth_pkg::ChanW'($urandom_range(0, m));
        if (k == 1) begin
          c[1] = c[2];
          c[2] = m;
        end else if (k == 2) begin
          c[0] = c[2];
          c[2] = m;
        end
      end
      2: begin
        m = rth_pkg::ChanW'($urandom_range(0, 254));
        c[0] = m + rth_pkg::ChanW'($urandom_range(0, 1));
        c[1] = m + rth_pkg::ChanW'($urandom_range(0, 1));
        c[2] = m + rth_pkg::ChanW'($urandom_range(0, 1));
      end
      default: begin
        c[0] = rth_pkg::ChanW'($urandom);
        c[1] = rth_pkg::ChanW'($urandom);
        c[2] = rth_pkg::ChanW'($urandom);
      end
    endcase
    send_pixel(c[0], c[1], c[2], tile);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_red         = '0;
    in_green       = '0;
    in_blue        = '0;
    in_end_of_tile = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd200, 8'd0, 8'd7, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd1, 1'b0);
    send_pixel(8'd128, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    send_pixel(8'd255, 8'd128, 8'd0, 1'b1);
    send_pixel(8'd254, 8'd255, 8'd253, 1'b0);
    send_pixel(8'd100, 8'd99, 8'd100, 1'b1);
    send_pixel(8'd255, 8'd254, 8'd255, 1'b0);
    send_pixel(8'd170, 8'd85, 8'd1, 1'b1);

    for (int n = 0; n < RandomPixels; n++) begin
      steady = (n >= 700 && n < 1100);
      send_random_pixel();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_hues.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
